[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL; every check is clocked on i_clk and
// held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in any cycle in which the antecedent holds.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/tlf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlf_pkg
// Types, constants and helpers shared by the text line folder modules.
// ----------------------------------------------------------------------------
package tlf_pkg;

    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned FOLD_W        = 7;
    localparam int unsigned MAX_WIDTH_DEF = 64;
    localparam int unsigned MIN_FOLD      = 2;

    localparam logic [FOLD_W-1:0] FOLD_WIDTH_RST = 7'd64;

    localparam logic [CHAR_W-1:0] BLANK_CODE = 8'h20;
    localparam logic [CHAR_W-1:0] NL_CODE    = 8'h0A;

    // Register map: word index taken from paddr above the byte offset
    localparam int unsigned APB_AW = 3;
    localparam logic [APB_AW-3:0] REG_FOLD_WIDTH = 1'b0;

    // Input command queue
    localparam int unsigned INQ_DEPTH = 2;
    localparam int unsigned INQ_AW    = $clog2(INQ_DEPTH);
    localparam int unsigned INQ_CW    = $clog2(INQ_DEPTH + 1);
    localparam logic [INQ_CW-1:0] INQ_FULL = INQ_CW'(INQ_DEPTH);

    // Result queue
    localparam int unsigned OUTQ_DEPTH = 4;
    localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_LW    = $clog2(OUTQ_DEPTH + 1);
    localparam logic [OUTQ_LW-1:0] OUTQ_FULL = OUTQ_LW'(OUTQ_DEPTH);

    typedef enum logic {
        CMD_CHAR  = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    // Classified input transaction
    typedef struct packed {
        logic              flush;
        logic [CHAR_W-1:0] ch;
    } t_item;

    // One emitted character
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_res;

    // Clamp the programmed width to the supported range
    function automatic logic [FOLD_W-1:0] fold_width_clamp(
        input logic [FOLD_W-1:0] width,
        input logic [FOLD_W-1:0] max_width
    );
        logic [FOLD_W-1:0] res;
        res = width;
        if (width < FOLD_W'(MIN_FOLD)) begin
            res = FOLD_W'(MIN_FOLD);
        end else if (width > max_width) begin
            res = max_width;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[sv/tlf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/tlf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlf_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module tlf_front
    import tlf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tvalid,
    output logic                   o_tready,
    input  wire logic [CHAR_W-1:0] i_tdata,   // [7:0] char_in
    input  wire logic              i_tuser,   // [0] cmd
    output logic                   o_item_valid,
    output t_item                  o_item,
    input  wire logic              i_item_pop
);

    t_item               r_q [INQ_DEPTH];
    logic [INQ_AW-1:0]   r_wp, n_wp;
    logic [INQ_AW-1:0]   r_rp, n_rp;
    logic [INQ_CW-1:0]   r_cnt, n_cnt;
    logic                w_push;
    t_item               w_item;

    always_comb begin
        o_tready     = (r_cnt != INQ_FULL);
        w_push       = i_tvalid && o_tready;
        // newline and end of stream both flush the line
        w_item.flush = (t_cmd'(i_tuser) == CMD_FLUSH) || (i_tdata == NL_CODE);
        w_item.ch    = i_tdata;

        n_wp  = w_push ? r_wp + INQ_AW'(1) : r_wp;
        n_rp  = i_item_pop ? r_rp + INQ_AW'(1) : r_rp;
        n_cnt = r_cnt + INQ_CW'(w_push) - INQ_CW'(i_item_pop);

        o_item_valid = (r_cnt != '0);
        o_item       = r_q[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule
`default_nettype wire

[sv/tlf_outq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlf_outq
// Result queue between the back end and the output stream.
// ----------------------------------------------------------------------------
module tlf_outq
    import tlf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire t_res               i_res,
    output logic [OUTQ_LW-1:0]      o_level,
    output logic                    o_tvalid,
    input  wire logic               i_tready,
    output logic [CHAR_W-1:0]       o_tdata,   // [7:0] char_out
    output logic                    o_tlast    // line_end
);

    t_res                r_q [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]  r_wp, n_wp;
    logic [OUTQ_AW-1:0]  r_rp, n_rp;
    logic [OUTQ_LW-1:0]  r_level, n_level;
    logic                w_pop;
    t_res                w_head;

    always_comb begin
        o_tvalid = (r_level != '0);
        w_pop    = o_tvalid && i_tready;
        w_head   = r_q[r_rp];
        o_tdata  = w_head.ch;
        o_tlast  = w_head.last;
        n_wp     = i_push ? r_wp + OUTQ_AW'(1) : r_wp;
        n_rp     = w_pop ? r_rp + OUTQ_AW'(1) : r_rp;
        n_level  = r_level + OUTQ_LW'(i_push) - OUTQ_LW'(w_pop);
        o_level  = r_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule
`default_nettype wire

[sv/tlf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlf_back
// Line buffer, fold-point search and segment emission.
// ----------------------------------------------------------------------------
module tlf_back
    import tlf_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [FOLD_W-1:0]  i_fold_width,
    input  wire logic               i_item_valid,
    input  wire t_item              i_item,
    output logic                    o_item_pop,
    input  wire logic [OUTQ_LW-1:0] i_outq_level,
    output logic                    o_res_push,
    output t_res                    o_res
);

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_EMIT   = 3'b100
    } t_bstate;

    t_bstate               r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_start, n_start;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_n, n_n;
    t_item                 r_item, n_item;
    logic                  r_rd_pend, n_rd_pend;
    logic                  r_rd_last, n_rd_last;
    logic                  r_chk, n_chk;

    logic [CW-1:0]         w_width;
    logic                  w_room;
    logic                  w_emit_last;
    logic [AW-1:0]         w_store_addr;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_next_start;
    logic                  w_we;
    logic [CHAR_W-1:0]     w_wdata;
    logic                  w_re;
    logic [CHAR_W-1:0]     w_rdata;

    // Buffer slot of a line position: wrap once around the circular store
    function automatic logic [AW-1:0] slot_of(
        input logic [AW-1:0] base,
        input logic [CW-1:0] pos
    );
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(pos);
        if (sum >= (CW+1)'(MAX_WIDTH)) begin
            sum = sum - (CW+1)'(MAX_WIDTH);
        end
        return sum[AW-1:0];
    endfunction

    always_comb begin
        w_width      = CW'(fold_width_clamp(i_fold_width, FOLD_W'(MAX_WIDTH)));
        w_room       = ((OUTQ_LW+1)'(i_outq_level) + (OUTQ_LW+1)'(r_rd_pend))
                       < (OUTQ_LW+1)'(OUTQ_DEPTH);
        w_emit_last  = ((CW+1)'(r_pos) + (CW+1)'(1)) == (CW+1)'(r_n);
        w_store_addr = slot_of(r_start, r_count);
        w_rd_addr    = slot_of(r_start, r_pos);
        w_next_start = slot_of(r_start, r_n);

        n_state   = r_state;
        n_count   = r_count;
        n_start   = r_start;
        n_pos     = r_pos;
        n_n       = r_n;
        n_item    = r_item;
        n_rd_pend = 1'b0;
        n_rd_last = r_rd_last;
        n_chk     = 1'b0;
        o_item_pop = 1'b0;
        w_we      = 1'b0;
        w_wdata   = i_item.ch;
        w_re      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    if (i_item.flush) begin
                        // an empty line gives nothing
                        if (r_count != '0) begin
                            n_item  = i_item;
                            n_n     = r_count;
                            n_pos   = '0;
                            n_state = S_EMIT;
                        end
                    end else if (r_count >= w_width) begin
                        n_item  = i_item;
                        n_pos   = w_width - CW'(1);
                        n_state = S_SEARCH;
                    end else begin
                        w_we    = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
            end
            S_SEARCH: begin
                // walk down from width-1, one read per cycle; the data checked
                // belongs to position r_pos+1, and position zero never counts
                if (r_chk && (w_rdata == BLANK_CODE)) begin
                    n_n     = r_pos + CW'(2);
                    n_pos   = '0;
                    n_state = S_EMIT;
                end else if (r_chk && (r_pos == '0)) begin
                    n_n     = w_width;
                    n_pos   = '0;
                    n_state = S_EMIT;
                end else begin
                    w_re  = 1'b1;
                    n_chk = 1'b1;
                    n_pos = r_pos - CW'(1);
                end
            end
            S_EMIT: begin
                if (w_room) begin
                    w_re      = 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_last = w_emit_last;
                    if (w_emit_last) begin
                        n_state = S_IDLE;
                        if (r_item.flush) begin
                            n_count = '0;
                            n_start = '0;
                        end else begin
                            // keep the remainder and append the held character
                            n_start  = w_next_start;
                            n_count  = r_count - r_n + CW'(1);
                            w_we     = 1'b1;
                            w_wdata  = r_item.ch;
                        end
                    end else begin
                        n_pos = r_pos + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_start   <= '0;
            r_rd_pend <= 1'b0;
            r_chk     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_start   <= n_start;
            r_rd_pend <= n_rd_pend;
            r_chk     <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_n       <= n_n;
        r_item    <= n_item;
        r_rd_last <= n_rd_last;
    end

    tlf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_store_addr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    assign o_res_push = r_rd_pend;
    assign o_res      = '{ch: w_rdata, last: r_rd_last};

endmodule
`default_nettype wire

[sv/text_line_folder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_folder_unit
// Folds a byte stream into lines of at most fold_width (clamped) characters.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata[7:0] char_in, tuser cmd
//  m_axis    out  tvalid/tready          tdata[7:0] char_out, tlast line_end
//  apb       in   psel/penable/pready    fold_width at byte address 0
//
//  The back end takes one transaction from the front queue per cycle when
//  idle; a character that fits the line is stored in that cycle. The front
//  queue takes one transaction per cycle while it has room.
//  A fold then adds a search, one position per cycle behind the registered
//  line store read, and the emission of the segment; a flush emits the
//  buffered characters. Emission waits while the result queue is short of room.
//  Synchronous active-low reset empties both queues and the line; no
//  clearing pass is needed. Output stalls back up through the result queue
//  into the back end and then the front queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_line_folder_unit
    import tlf_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] char_in
    input  wire logic              s_axis_tuser,   // [0] cmd
    // output stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [CHAR_W-1:0]      m_axis_tdata,   // [7:0] char_out
    output logic                   m_axis_tlast,   // line_end
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [FOLD_W-1:0]  r_fold_width;
    logic               w_cfg_sel;
    logic               w_item_valid;
    t_item              w_item;
    logic               w_item_pop;
    logic [OUTQ_LW-1:0] w_outq_level;
    logic               w_res_push;
    t_res               w_res;

    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[APB_AW-1:2] == REG_FOLD_WIDTH);
    assign prdata    = w_cfg_sel ? 32'(r_fold_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_width <= FOLD_WIDTH_RST;
        end else if (psel && penable && pwrite && pready && w_cfg_sel) begin
            r_fold_width <= pwdata[FOLD_W-1:0];
        end
    end

    tlf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_tdata      (s_axis_tdata),
        .i_tuser      (s_axis_tuser),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    tlf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fold_width (r_fold_width),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .i_outq_level (w_outq_level),
        .o_res_push   (w_res_push),
        .o_res        (w_res)
    );

    tlf_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_push),
        .i_res    (w_res),
        .o_level  (w_outq_level),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    `ASSERT_IMPLIES(a_pop_has_item, w_item_pop, w_item_valid, "pop from empty command queue")
    `ASSERT_IMPLIES(a_push_has_room, w_res_push, w_outq_level != OUTQ_FULL, "result queue overrun")
    `ASSERT_ALWAYS(a_level_bound, w_outq_level <= OUTQ_FULL, "result queue level out of range")

endmodule
`default_nettype wire
